### rtl/core/afsk_nrzi_tone_modulator_top_assert.svh
// Assertion macros for the AFSK modulator checker.
`ifndef AFSK_NRZI_TONE_MODULATOR_TOP_ASSERT_SVH
`define AFSK_NRZI_TONE_MODULATOR_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define AFSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afsk: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define AFSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afsk: next-cycle check failed");

`endif

### rtl/core/afsk_pkg.sv
package afsk_pkg;

  // input item
  typedef struct packed {
    logic bit_value;
    logic first_bit;
    logic last_bit;
  } in_t;

  // result item
  typedef struct packed {
    logic [7:0] sample;
    logic       bit_done;
    logic       packet_done;
  } out_t;

  // register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MARK_STEP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPACE_STEP  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPB_Q8      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRE_EMPH_ON = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] MARK_STEP_RST  = 16'd1258;
  localparam logic [15:0] SPACE_STEP_RST = 16'd2306;
  localparam logic [14:0] SPB_Q8_RST     = 15'd13333;

  localparam int unsigned TABLE_DEPTH_DEF = 512;
  localparam int unsigned MAX_SPB_DEF     = 64;

  localparam logic [7:0] EMPH_OFFSET = 8'd64;
  localparam logic [15:0] ONE_SAMPLE_Q8 = 16'd256;

  // sine table generation, elaboration only
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] Q30_HALF = 64'd536870912;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

  // round(127*sin) quarter wave by integer Taylor series in Q30, k in 0..128
  function automatic logic [6:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] q;
    x    = (PI_Q30 * 64'(k)) >> 8;
    term = x;
    pos  = x;
    neg  = '0;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    if (neg >= pos) begin
      q = '0;
    end else begin
      q = ((pos - neg) * 64'd127 + Q30_HALF) >> 30;
      if (q > 64'd127) begin
        q = 64'd127;
      end
    end
    return q[6:0];
  endfunction

  // entry idx of a table with 2**addr_bits entries
  function automatic logic [7:0] sine_entry(input int unsigned idx,
                                            input int unsigned addr_bits);
    int unsigned a;
    int unsigned k;
    logic [7:0]  q;
    a = (idx << (9 - addr_bits)) & 511;
    k = a & 255;
    if (k > 128) begin
      k = 256 - k;
    end
    q = {1'b0, quarter_sine(k)};
    return (a < 256) ? (8'd128 + q) : (8'd128 - q);
  endfunction

endpackage

### rtl/core/afsk_nrzi_tone_modulator_top.sv
// AFSK modulator with NRZI coding: each input transfer carries one packet bit
// and yields between 1 and MAX_SAMPLES_PER_BIT output transfers of 8-bit audio
// samples; bit_done flags the final sample of the bit and packet_done the
// final sample of a bit sent with last_bit set. A bit yields about 52
// samples at reset values. The sample sequencer takes the bit in S_IDLE,
// then steps each sample through S_PHASE, S_BAUD and S_EMIT around a
// single shared 16-bit adder (phase step, then baud fraction step) and the
// registered sine ROM read; S_EMIT holds while out_stall is high.
// in_stall stays high from the input transfer until the last sample of the
// bit has been taken. Configuration writes are expected only while idle.
module afsk_nrzi_tone_modulator_top #(
  parameter int unsigned TABLE_DEPTH         = afsk_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_SAMPLES_PER_BIT = afsk_pkg::MAX_SPB_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // bit input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  afsk_pkg::in_t                       in_data,
  // sample output
  output logic                                out_valid,
  input  logic                                out_stall,
  output afsk_pkg::out_t                      out_data,
  // register writes
  input  logic                                cfg_we,
  input  logic [afsk_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [afsk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import afsk_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  // saturation bounds of samples per bit, 7.8
  localparam logic [14:0] SPB_MIN = 15'd256;
  localparam logic [14:0] SPB_MAX = 15'(MAX_SAMPLES_PER_BIT * 256);

  // sample sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,  // waiting for a bit
    S_PHASE = 4'b0010,  // phase += tone step, ROM read issued
    S_BAUD  = 4'b0100,  // baud fraction step, sample formed
    S_EMIT  = 4'b1000   // sample waits for its transfer
  } state_t;

  state_t      state_r, state_nxt;

  // configuration
  logic [15:0] mark_step_r;
  logic [15:0] space_step_r;
  logic [14:0] spb_q8_r;
  logic        pre_emph_r;

  // modulator state
  logic [15:0] phase_r, phase_nxt;
  logic [15:0] tone_r, tone_nxt;
  logic [14:0] frac_r, frac_nxt;
  logic        last_r, last_nxt;
  out_t        out_data_r, out_data_nxt;

  // shared adder
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [15:0] add_sum;

  logic [14:0] spb_eff;
  logic        bit_end;
  logic [15:0] tone_base;
  logic [7:0]  rom_q;
  logic [7:0]  sample_val;
  logic        in_xfer;

  assign in_xfer = in_valid && !in_stall;

  // effective samples per bit, clamped to [1, MAX] samples
  always_comb begin
    if (spb_q8_r < SPB_MIN) begin
      spb_eff = SPB_MIN;
    end else if (spb_q8_r > SPB_MAX) begin
      spb_eff = SPB_MAX;
    end else begin
      spb_eff = spb_q8_r;
    end
  end

  // operand select: phase step in S_PHASE, one sample of baud time otherwise
  always_comb begin
    if (state_r == S_PHASE) begin
      add_a = phase_r;
      add_b = tone_r;
    end else begin
      add_a = {1'b0, frac_r};
      add_b = ONE_SAMPLE_Q8;
    end
  end

  assign add_sum = add_a + add_b;

  // baud counter wraps when the sum reaches samples per bit
  assign bit_end = (add_sum >= {1'b0, spb_eff});

  // pre-emphasis only on the mark tone
  always_comb begin
    if (pre_emph_r && (tone_r == mark_step_r)) begin
      sample_val = {1'b0, rom_q[7:1]} + EMPH_OFFSET;
    end else begin
      sample_val = rom_q;
    end
  end

  // NRZI: a zero bit swaps mark and space, first bit restarts on mark
  assign tone_base = in_data.first_bit ? mark_step_r : tone_r;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    tone_nxt     = tone_r;
    frac_nxt     = frac_r;
    last_nxt     = last_r;
    out_data_nxt = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_PHASE;
          last_nxt  = in_data.last_bit;
          if (in_data.first_bit) begin
            phase_nxt = '0;
            frac_nxt  = '0;
          end
          if (in_data.bit_value) begin
            tone_nxt = tone_base;
          end else begin
            tone_nxt = tone_base ^ (mark_step_r ^ space_step_r);
          end
        end
      end
      S_PHASE: begin
        phase_nxt = add_sum;
        state_nxt = S_BAUD;
      end
      S_BAUD: begin
        if (bit_end) begin
          frac_nxt = 15'(add_sum - {1'b0, spb_eff});
        end else begin
          frac_nxt = add_sum[14:0];
        end
        out_data_nxt.sample      = sample_val;
        out_data_nxt.bit_done    = bit_end;
        out_data_nxt.packet_done = bit_end && last_r;
        state_nxt                = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          state_nxt = out_data_r.bit_done ? S_IDLE : S_PHASE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= '0;
      tone_r       <= MARK_STEP_RST;
      frac_r       <= '0;
      mark_step_r  <= MARK_STEP_RST;
      space_step_r <= SPACE_STEP_RST;
      spb_q8_r     <= SPB_Q8_RST;
      pre_emph_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      tone_r  <= tone_nxt;
      frac_r  <= frac_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MARK_STEP:   mark_step_r  <= cfg_wdata;
          CFG_SPACE_STEP:  space_step_r <= cfg_wdata;
          CFG_SPB_Q8:      spb_q8_r     <= cfg_wdata[14:0];
          CFG_PRE_EMPH_ON: pre_emph_r   <= cfg_wdata[0];
          default:         pre_emph_r   <= pre_emph_r;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  // ROM address is the integer part of the phase
  afsk_sine_rom #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_en   (state_r == S_PHASE),
    .rd_addr (add_sum[7 +: ADDR_W]),
    .rd_data (rom_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_data  = out_data_r;

endmodule

### rtl/core/afsk_sine_rom.sv
module afsk_sine_rom #(
  parameter int unsigned TABLE_DEPTH = afsk_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [7:0]                     rd_data
);
  import afsk_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  typedef logic [7:0] rom_array_t [TABLE_DEPTH];

  function automatic rom_array_t rom_init();
    rom_array_t r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = sine_entry(i, ADDR_W);
    end
    return r;
  endfunction

  localparam rom_array_t SINE_ROM = rom_init();

  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/afsk_checker.sv
`include "afsk_nrzi_tone_modulator_top_assert.svh"

module afsk_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input afsk_pkg::out_t out_data
);
  import afsk_pkg::*;

  // a sample held back keeps its value
  `AFSK_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // no new bit taken while a sample is pending
  `AFSK_ASSERT_IMP(a_busy_on_out, clk, rst_n, out_valid, in_stall)

  // packet end only on a bit end
  `AFSK_ASSERT_IMP(a_pkt_on_bit, clk, rst_n, out_valid && out_data.packet_done, out_data.bit_done)

  // a sample needs at least the phase and baud steps after the bit transfer
  `AFSK_ASSERT_NXT(a_first_gap, clk, rst_n, in_valid && !in_stall, !out_valid)

endmodule

bind afsk_nrzi_tone_modulator_top afsk_checker u_afsk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/tb_afsk_nrzi_tone_modulator_top.sv
module tb_afsk_nrzi_tone_modulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afsk_pkg::*;

  // Longest stretch of cycles with no transfer or write before the run is
  // declared hung. The worst legal quiet stretch is a receiver stall run
  // plus the steps of one sample, or a sender gap plus a settle.
  localparam int QUIET_LIMIT = 2000;
  localparam int unsigned Q8_ONE = 256;
  localparam int RAND_PHASES = 8;
  localparam int BITS_PER_PHASE = 40;
  localparam int MAX_PRINTED = 40;

  // A stimulus row is either a register write or one bit. Bit rows may carry
  // a hand-typed sample; those rows always produce exactly one sample.
  typedef enum logic {
    ROW_WRITE,
    ROW_BIT
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_ADDR_W-1:0]      addr;
    logic [CFG_DATA_W-1:0]      data;
    in_t                        item;
    logic                       typed;
    out_t                       want;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  afsk_nrzi_tone_modulator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Tone synthesizer mirror: register copies, DDS state and the sine table
  // ---------------------------------------------------------------------
  logic [15:0] reg_mark;
  logic [15:0] reg_space;
  logic [14:0] reg_spb;
  logic        reg_emph;

  logic [15:0] ph_acc;
  logic [15:0] cur_step;
  logic [14:0] baud_frac;
  logic [7:0]  sine_tab [512];

  out_t pending_samples[$];   // samples still owed by the block, oldest first
  row_t bits_in_flight[$];    // bit rows driven but not yet transferred
  int   mismatch_cnt = 0;
  int   burst_left = 0;

  // round(127*sin(2*pi*k/512)), k in 0..128: odd Taylor terms up to x^15
  // in Q30 with truncating steps, so the table matches bit for bit.
  function automatic int unsigned sine_amp(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned q;
    x    = (64'd3373259426 * longint'(k)) / 64'd256;
    term = x;
    pos  = x;
    neg  = 0;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    if (neg >= pos) begin
      return 0;
    end
    q = ((pos - neg) * 64'd127 + 64'd536870912) >> 30;
    return (q > 127) ? 127 : int'(q);
  endfunction

  // Produce every sample owed for one transferred bit.
  function automatic void synth_bit_samples(input in_t b);
    int unsigned eff_spb;
    int unsigned acc;
    int          cnt;
    logic        done;
    logic [7:0]  s;
    eff_spb = reg_spb;
    if (eff_spb < Q8_ONE) begin
      eff_spb = Q8_ONE;
    end
    if (eff_spb > MAX_SPB_DEF * Q8_ONE) begin
      eff_spb = MAX_SPB_DEF * Q8_ONE;
    end
    if (b.first_bit) begin
      ph_acc    = '0;
      baud_frac = '0;
      cur_step  = reg_mark;
    end
    // NRZI: zero swaps mark <-> space; equal steps make this a no-op
    if (!b.bit_value) begin
      cur_step = cur_step ^ reg_mark ^ reg_space;
    end
    cnt  = 0;
    done = 1'b0;
    while (!done && cnt < MAX_SPB_DEF) begin
      ph_acc = ph_acc + cur_step;
      s = sine_tab[ph_acc[15:7]];
      if (reg_emph && cur_step == reg_mark) begin
        s = s / 2 + EMPH_OFFSET;
      end
      acc  = int'(baud_frac) + Q8_ONE;
      done = (acc >= eff_spb);
      if (done) begin
        acc = acc - eff_spb;
      end
      baud_frac = acc[14:0];
      pending_samples.push_back(out_t'{s, done, done && b.last_bit});
      cnt++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------
  // Transfer monitor. Both sides are sampled at the edge itself, so the
  // input transfer is always predicted before any sample it causes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    row_t r;
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        r = bits_in_flight.pop_front();
        synth_bit_samples(in_data);
        // hand-typed rows are one-sample bits: the typed value replaces
        // the computed one, the DDS state still advances
        if (r.typed) begin
          pending_samples[$] = r.want;
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample transfer %0d", out_data.sample));
        end else begin
          want = pending_samples.pop_front();
          if (out_data.sample !== want.sample) begin
            report_mismatch($sformatf("sample got %0d want %0d",
                                      out_data.sample, want.sample));
          end
          if (out_data.bit_done !== want.bit_done) begin
            report_mismatch($sformatf("bit_done got %b want %b",
                                      out_data.bit_done, want.bit_done));
          end
          if (out_data.packet_done !== want.packet_done) begin
            report_mismatch($sformatf("packet_done got %b want %b",
                                      out_data.packet_done, want.packet_done));
          end
        end
      end
    end
  end

  // Hang detector: any transfer or write restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver back-pressure: a mode is held for a random stretch; modes are
  // no stall, coin flip, rare stall, and long alternating stall runs.
  // ---------------------------------------------------------------------
  logic [1:0] stall_mode = 2'd0;
  int         mode_left = 0;
  int         run_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0: begin
        out_stall <= 1'b0;
      end
      2'd1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (run_left == 0) begin
          out_stall <= !out_stall;
          run_left  <= $urandom_range(1, 30);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic row_t cfg_row(input logic [CFG_ADDR_W-1:0] a,
                                   input logic [CFG_DATA_W-1:0] d);
    return row_t'{ROW_WRITE, a, d, in_t'('0), 1'b0, out_t'('0)};
  endfunction

  function automatic row_t bit_row(input logic b, input logic f, input logic l);
    return row_t'{ROW_BIT, '0, '0, in_t'{b, f, l}, 1'b0, out_t'('0)};
  endfunction

  function automatic row_t known_row(input logic b, input logic f, input logic l,
                                     input logic [7:0] s, input logic bd,
                                     input logic pd);
    row_t r;
    r       = bit_row(b, f, l);
    r.typed = 1'b1;
    r.want  = out_t'{s, bd, pd};
    return r;
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return MARK_STEP_RST;
      3: return 16'(16384 * $urandom_range(1, 3));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Offer one bit; the sender works in bursts with idle gaps between them.
  task automatic send_bit(input row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    bits_in_flight.push_back(r);
    in_data  <= r.item;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Let the block finish the bit in progress and every owed sample drain,
  // then wait out the tail, so that the block is idle before a register
  // write or the end of the run.
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_stall || pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (tail) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_addr  <= a;
    cfg_wdata <= d;
    cfg_we    <= 1'b1;
    @(posedge clk);
    case (a)
      CFG_MARK_STEP:   reg_mark  = d;
      CFG_SPACE_STEP:  reg_space = d;
      CFG_SPB_Q8:      reg_spb   = d[14:0];
      CFG_PRE_EMPH_ON: reg_emph  = d[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    row_t        dir_rows[$];
    logic [15:0] mark_val;
    logic [15:0] spb_val;
    int          sent;
    int          len;

    for (int i = 0; i < 512; i++) begin
      int unsigned k;
      k = i & 255;
      if (k > 128) begin
        k = 256 - k;
      end
      sine_tab[i] = (i < 256) ? 8'(128 + sine_amp(k)) : 8'(128 - sine_amp(k));
    end
    reg_mark  = MARK_STEP_RST;
    reg_space = SPACE_STEP_RST;
    reg_spb   = SPB_Q8_RST;
    reg_emph  = 1'b0;
    ph_acc    = '0;
    cur_step  = MARK_STEP_RST;
    baud_frac = '0;

    // Directed table. Quarter-turn steps with one sample per bit land the
    // phase on the table's peak, midpoint and trough, so the samples can be
    // typed in: peak 255, mid 128, trough 1; with pre-emphasis on a mark
    // tone these become 191, 128 and 64.
    dir_rows = '{
      cfg_row(CFG_MARK_STEP,  16'd16384),
      cfg_row(CFG_SPACE_STEP, 16'd49152),
      cfg_row(CFG_SPB_Q8,     16'd256),
      known_row(1'b1, 1'b1, 1'b0, 8'd255, 1'b1, 1'b0),  // packet start, mark, peak
      known_row(1'b1, 1'b0, 1'b0, 8'd128, 1'b1, 1'b0),  // one keeps the tone
      known_row(1'b0, 1'b0, 1'b0, 8'd255, 1'b1, 1'b0),  // zero swaps to space
      known_row(1'b0, 1'b0, 1'b0, 8'd128, 1'b1, 1'b0),  // and back to mark
      known_row(1'b1, 1'b0, 1'b1, 8'd1,   1'b1, 1'b1),  // last bit of the packet
      known_row(1'b1, 1'b0, 1'b0, 8'd128, 1'b1, 1'b0),  // past the last bit, phase wraps
      cfg_row(CFG_PRE_EMPH_ON, 16'd1),
      known_row(1'b1, 1'b1, 1'b0, 8'd191, 1'b1, 1'b0),  // emphasized mark
      known_row(1'b0, 1'b0, 1'b0, 8'd128, 1'b1, 1'b0),  // space left alone
      known_row(1'b0, 1'b0, 1'b0, 8'd191, 1'b1, 1'b0),
      known_row(1'b1, 1'b0, 1'b0, 8'd128, 1'b1, 1'b0),
      known_row(1'b1, 1'b0, 1'b1, 8'd64,  1'b1, 1'b1),
      cfg_row(CFG_SPACE_STEP, 16'd16384),  // mark equals space
      known_row(1'b0, 1'b1, 1'b0, 8'd191, 1'b1, 1'b0),  // zero cannot change the tone
      known_row(1'b0, 1'b0, 1'b0, 8'd128, 1'b1, 1'b0),
      cfg_row(CFG_SPB_Q8, 16'd0),        // below one sample: saturates up
      known_row(1'b1, 1'b1, 1'b1, 8'd191, 1'b1, 1'b1),
      cfg_row(CFG_SPB_Q8, 16'h7FFF),     // above the ceiling: 64 samples
      bit_row(1'b0, 1'b0, 1'b1),
      cfg_row(CFG_MARK_STEP,   16'd1),
      cfg_row(CFG_SPACE_STEP,  16'hFFFF),
      cfg_row(CFG_PRE_EMPH_ON, 16'd0),
      cfg_row(CFG_SPB_Q8,      16'd16384),  // exactly 64 samples
      bit_row(1'b1, 1'b1, 1'b0),
      bit_row(1'b0, 1'b0, 1'b1),
      cfg_row(CFG_SPB_Q8, 16'd300),      // fractional carry between bits
      bit_row(1'b1, 1'b1, 1'b0),
      bit_row(1'b0, 1'b0, 1'b0),
      bit_row(1'b1, 1'b0, 1'b1),
      cfg_row(CFG_MARK_STEP,  MARK_STEP_RST),
      cfg_row(CFG_SPACE_STEP, SPACE_STEP_RST),
      cfg_row(CFG_SPB_Q8,     {1'b0, SPB_Q8_RST}),
      bit_row(1'b1, 1'b1, 1'b0),
      bit_row(1'b0, 1'b0, 1'b0),
      bit_row(1'b0, 1'b0, 1'b1)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle(4);
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_bit(dir_rows[i]);
      end
    end

    // Random phases: fresh register settings each phase, then mostly
    // well-formed packets with random bits, with some loose bits mixed in.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle(4);
      mark_val = pick_step();
      write_reg(CFG_MARK_STEP, mark_val);
      write_reg(CFG_SPACE_STEP, ($urandom_range(0, 7) == 0) ? mark_val : pick_step());
      case ($urandom_range(0, 9))
        0: spb_val = 16'($urandom_range(0, 255));
        1: spb_val = 16'($urandom_range(16385, 32767));
        2: spb_val = {1'b0, SPB_Q8_RST};
        3: spb_val = 16'd16384;
        4: spb_val = 16'd256;
        default: spb_val = 16'($urandom_range(256, 2560));
      endcase
      write_reg(CFG_SPB_Q8, spb_val);
      write_reg(CFG_PRE_EMPH_ON, 16'($urandom_range(0, 1)));
      sent = 0;
      while (sent < BITS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(1, 24);
          for (int i = 0; i < len; i++) begin
            send_bit(bit_row(1'($urandom_range(0, 1)), i == 0, i == len - 1));
          end
        end else begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            send_bit(bit_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))));
          end
        end
        sent += len;
      end
    end

    // Anything still owed here shows up as a hang and trips the watchdog.
    settle(10);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### afsk_nrzi_tone_modulator_top.f
+incdir+rtl/core
rtl/core/afsk_pkg.sv
rtl/core/afsk_sine_rom.sv
rtl/core/afsk_nrzi_tone_modulator_top.sv
rtl/core/afsk_checker.sv
dv/tb_afsk_nrzi_tone_modulator_top.sv
